>>> sv/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the IPv4 LPM trie forwarder
// Status codes, operation codes, register map and address constants.
// ----------------------------------------------------------------------------
package lpm_pkg;

	localparam int ADDR_BITS = 32;
	localparam int PLEN_W    = 6;
	localparam int TTL_W     = 8;

	localparam logic [ADDR_BITS-1:0] BCAST_ADDR = 32'hFFFF_FFFF;

	// operation field
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_FWD = 1'b1;

	// register index (word address bit 2 of paddr)
	localparam logic REG_LOCAL_ADDR = 1'b0;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_FULL    = 3'd1,
		ST_LOCAL   = 3'd2,
		ST_FWD     = 3'd3,
		ST_TTL     = 3'd4,
		ST_NOROUTE = 3'd5
	} status_t;

endpackage

>>> sv/lpm_req_if.sv
// ----------------------------------------------------------------------------
// lpm_req_if: request channel of the LPM trie forwarder
// Valid/ready channel carrying one route add or packet forward request.
// ----------------------------------------------------------------------------
interface lpm_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] dest_addr;
	logic [5:0]  prefix_len;
	logic [31:0] next_hop;
	logic [7:0]  ttl;

	modport source (
		output valid, operation, dest_addr, prefix_len, next_hop, ttl,
		input  ready
	);
	modport sink (
		input  valid, operation, dest_addr, prefix_len, next_hop, ttl,
		output ready
	);
endinterface

>>> sv/lpm_rsp_if.sv
// ----------------------------------------------------------------------------
// lpm_rsp_if: response channel of the LPM trie forwarder
// Valid/ready channel carrying one status, next hop and new TTL.
// ----------------------------------------------------------------------------
interface lpm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] out_next_hop;
	logic [7:0]  new_ttl;

	modport source (
		output valid, status, out_next_hop, new_ttl,
		input  ready
	);
	modport sink (
		input  valid, status, out_next_hop, new_ttl,
		output ready
	);
endinterface

>>> sv/ipv4_lpm_forward_trie_top.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_forward_trie_top: IPv4 route table as a binary trie
// Route insertion and longest prefix match forwarding over a node memory.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+------------------------------------------
//  req     | in  | valid/ready     | operation, dest_addr, prefix_len,
//          |     |                 | next_hop, ttl
//  rsp     | out | valid/ready     | status, out_next_hop, new_ttl
//  apb     | in  | psel/penable    | local_addr at byte address 0
//
//  Sequence: one request at a time. A lookup is accepted in the idle state,
//  walks the trie one level at a time (up to 33 levels), then loads the result
//  register in the put state. The node memory read port returns one node per
//  cycle and paces the walk. An add checks each existing level and, for each
//  allocated node, writes the new node, then relinks the parent. Local or
//  broadcast packets go from the idle state straight to the put state.
//  Reset: the root is empty through a root-written flag; no clearing pass.
//  Stalls: a new request is taken while a result still waits in the output
//  register; the block holds in its put state until that register frees up.
//
module ipv4_lpm_forward_trie_top #(
	parameter int NODE_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	lpm_req_if.sink            req,
	lpm_rsp_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import lpm_pkg::*;

	localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CNT_W = $clog2(NODE_COUNT + 1);

	typedef struct packed {
		logic                 has_route;
		logic [ADDR_BITS-1:0] hop;
		logic [IDX_W-1:0]     child0;
		logic [IDX_W-1:0]     child1;
	} node_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACHK,   // add: examine current node
		S_ALINK,  // add: link freshly allocated child into parent
		S_LCHK,   // lookup: examine current node
		S_PUT     // load the result register
	} state_t;

	// ---------------------------------------------------------------- registers
	state_t               state_q;
	logic [IDX_W-1:0]     cur_q;       // index of node held in rdata_q
	logic [PLEN_W-1:0]    depth_q;
	logic [CNT_W-1:0]     used_q;      // allocated node count
	logic                 root_ok_q;   // root has been written since reset
	logic                 op_q;
	logic [ADDR_BITS-1:0] dest_q;
	logic [PLEN_W-1:0]    plen_q;
	logic [ADDR_BITS-1:0] hop_q;
	logic [TTL_W-1:0]     ttl_q;
	logic                 found_q;
	logic [ADDR_BITS-1:0] best_q;
	node_t                link_q;      // parent node with new child pointer
	status_t              res_status_q;
	logic [ADDR_BITS-1:0] res_hop_q;
	logic [TTL_W-1:0]     res_ttl_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ADDR_BITS-1:0] out_hop_q;
	logic [TTL_W-1:0]     out_ttl_q;
	logic [ADDR_BITS-1:0] local_addr_q;

	// ---------------------------------------------------------------- node memory
	node_t                mem [NODE_COUNT];
	node_t                rdata_q;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	node_t                wr_data;
	logic [IDX_W-1:0]     rd_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// ---------------------------------------------------------------- walk logic
	node_t                node;
	node_t                link_d;
	logic [4:0]           lvl;
	logic                 bit_sel;
	logic [IDX_W-1:0]     nxt;
	logic                 add_end;
	logic                 pool_full;
	logic                 lk_end;
	logic                 lk_found;
	logic [ADDR_BITS-1:0] lk_hop;
	logic                 is_local;
	logic [PLEN_W-1:0]    plen_sat;

	// the root reads as empty until first written; every other node is written
	// when allocated, before any read of it
	assign node      = (cur_q == '0 && !root_ok_q) ? node_t'('0) : rdata_q;
	assign lvl       = 5'(ADDR_BITS - 1) - depth_q[4:0];
	assign bit_sel   = dest_q[lvl];
	assign nxt       = bit_sel ? node.child1 : node.child0;
	assign add_end   = (depth_q == plen_q);
	assign pool_full = (used_q == CNT_W'(NODE_COUNT));
	assign lk_end    = (depth_q == PLEN_W'(ADDR_BITS)) || (nxt == '0);
	assign lk_found  = found_q || node.has_route;
	assign lk_hop    = node.has_route ? node.hop : best_q;
	assign is_local  = (req.dest_addr == BCAST_ADDR) || (req.dest_addr == local_addr_q);
	assign plen_sat  = (req.prefix_len > PLEN_W'(ADDR_BITS)) ? PLEN_W'(ADDR_BITS)
	                                                          : req.prefix_len;

	// parent image with the pool head hooked onto the branch taken
	always_comb begin
		link_d = node;
		if (bit_sel) begin
			link_d.child1 = used_q[IDX_W-1:0];
		end else begin
			link_d.child0 = used_q[IDX_W-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = node;
		rd_addr = '0;
		case (state_q)
			S_ACHK: begin
				if (add_end) begin
					wr_en             = 1'b1;
					wr_data.has_route = 1'b1;
					wr_data.hop       = hop_q;
				end else if (nxt != '0) begin
					rd_addr = nxt;
				end else if (!pool_full) begin
					// fresh empty node at the pool head
					wr_en   = 1'b1;
					wr_addr = used_q[IDX_W-1:0];
					wr_data = '0;
				end
			end
			S_ALINK: begin
				wr_en   = 1'b1;
				wr_data = link_q;
				rd_addr = used_q[IDX_W-1:0];
			end
			S_LCHK: begin
				rd_addr = nxt;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			depth_q      <= '0;
			used_q       <= CNT_W'(1);
			root_ok_q    <= 1'b0;
			op_q         <= OP_ADD;
			dest_q       <= '0;
			plen_q       <= '0;
			hop_q        <= '0;
			ttl_q        <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			link_q       <= '0;
			res_status_q <= ST_ADDED;
			res_hop_q    <= '0;
			res_ttl_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_ADDED;
			out_hop_q    <= '0;
			out_ttl_q    <= '0;
			local_addr_q <= '0;
		end else begin
			if (psel && penable && pwrite && paddr[2] == REG_LOCAL_ADDR) begin
				local_addr_q <= pwdata;
			end
			if (wr_en && wr_addr == '0) begin
				root_ok_q <= 1'b1;
			end
			// the put state reloads the output register itself
			if (rsp.ready && state_q != S_PUT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.operation;
						dest_q  <= req.dest_addr;
						plen_q  <= plen_sat;
						hop_q   <= req.next_hop;
						ttl_q   <= req.ttl;
						cur_q   <= '0;
						depth_q <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						if (req.operation == OP_ADD) begin
							state_q <= S_ACHK;
						end else if (is_local) begin
							res_status_q <= ST_LOCAL;
							res_hop_q    <= '0;
							res_ttl_q    <= '0;
							state_q      <= S_PUT;
						end else begin
							state_q <= S_LCHK;
						end
					end
				end
				S_ACHK: begin
					if (add_end) begin
						res_status_q <= ST_ADDED;
						res_hop_q    <= '0;
						res_ttl_q    <= '0;
						state_q      <= S_PUT;
					end else if (nxt != '0) begin
						cur_q   <= nxt;
						depth_q <= depth_q + PLEN_W'(1);
					end else if (pool_full) begin
						res_status_q <= ST_FULL;
						res_hop_q    <= '0;
						res_ttl_q    <= '0;
						state_q      <= S_PUT;
					end else begin
						link_q  <= link_d;
						state_q <= S_ALINK;
					end
				end
				S_ALINK: begin
					cur_q   <= used_q[IDX_W-1:0];
					used_q  <= used_q + CNT_W'(1);
					depth_q <= depth_q + PLEN_W'(1);
					state_q <= S_ACHK;
				end
				S_LCHK: begin
					found_q <= lk_found;
					best_q  <= lk_hop;
					if (lk_end) begin
						if (!lk_found) begin
							res_status_q <= ST_NOROUTE;
							res_hop_q    <= '0;
							res_ttl_q    <= '0;
						end else if (ttl_q == '0) begin
							res_status_q <= ST_TTL;
							res_hop_q    <= '0;
							res_ttl_q    <= '0;
						end else begin
							res_status_q <= ST_FWD;
							res_hop_q    <= lk_hop;
							res_ttl_q    <= ttl_q - TTL_W'(1);
						end
						state_q <= S_PUT;
					end else begin
						cur_q   <= nxt;
						depth_q <= depth_q + PLEN_W'(1);
					end
				end
				S_PUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_hop_q    <= res_hop_q;
						out_ttl_q    <= res_ttl_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- ports
	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_next_hop = out_hop_q;
	assign rsp.new_ttl      = out_ttl_q;
	assign pready           = 1'b1;
	assign prdata           = (paddr[2] == REG_LOCAL_ADDR) ? local_addr_q : '0;

	// ---------------------------------------------------------------- assertions
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(NODE_COUNT))
		else $error("node pool count beyond pool size");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != S_IDLE && state_q != S_PUT))
		else $error("node memory written outside a walk");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ALINK |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("allocation did not advance pool head");

	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FWD) |-> rsp.new_ttl != 8'hFF)
		else $error("forward result with impossible TTL");

	a_op_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACHK || state_q == S_ALINK) |-> op_q == OP_ADD)
		else $error("add walk running for a forward request");

endmodule

>>> sim/tb_ipv4_lpm_forward_trie_top.sv
// ----------------------------------------------------------------------------
// tb_ipv4_lpm_forward_trie_top: self-checking bench for the IPv4 LPM trie
// Feeds route adds and packet forwards through the request channel with
// random gaps and response stalls. A local trie predicts each verdict, and
// responses are checked field by field in order. local_addr is reprogrammed
// over APB between traffic phases and read back.
// ----------------------------------------------------------------------------
module tb_ipv4_lpm_forward_trie_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpm_pkg::*;

	localparam int NODE_COUNT     = 1024;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;
	localparam logic [2:0] LOCAL_ADDR_OFS = {REG_LOCAL_ADDR, 2'b00};

	typedef struct packed {
		logic        operation;
		logic [31:0] dest_addr;
		logic [5:0]  prefix_len;
		logic [31:0] next_hop;
		logic [7:0]  ttl;
	} route_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_next_hop;
		logic [7:0]  new_ttl;
	} verdict_t;

	// clock and reset; reset drops through an NBA at time zero so the
	// driver processes see a real negedge and load known values
	logic clk    = 1'b0;
	logic arst_n = 1'b1;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lpm_req_if req_ch ();
	lpm_rsp_if rsp_ch ();

	ipv4_lpm_forward_trie_top #(
		.NODE_COUNT(NODE_COUNT)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow route table: same node pool, same allocation order
	// ------------------------------------------------------------------
	logic        trie_route [NODE_COUNT]    = '{default: 1'b0};
	logic [31:0] trie_hop   [NODE_COUNT]    = '{default: 32'd0};
	int unsigned trie_child [NODE_COUNT][2] = '{default: '{default: 0}};
	int unsigned nodes_alloc = 1;          // root only
	logic [31:0] router_addr = 32'd0;      // shadow of local_addr

	route_req_t  route_requests [$];       // waiting for the driver
	verdict_t    expected_verdicts [$];    // accepted, response not seen yet
	logic [31:0] route_bases [8];          // address clusters for adds
	logic [31:0] added_dests [$];          // targets for forwards

	int reqs_queued   = 0;
	int reqs_accepted = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	logic req_taken;
	int   send_gap, send_calm;
	int   hold_cnt, hold_calm;
	route_req_t head_req;

	// walk the trie the way the block does: add allocates, forward finds the
	// deepest node carrying a route
	function automatic verdict_t forward_decision(route_req_t r);
		verdict_t    res;
		int unsigned cur, nxt, span, d;
		logic        br, found, full;
		logic [31:0] hit_hop;
		res     = '{ST_ADDED, 32'd0, 8'd0};
		cur     = 0;
		found   = 1'b0;
		full    = 1'b0;
		hit_hop = 32'd0;
		if (r.operation == OP_ADD) begin
			// over-long prefixes saturate at 32
			span = (r.prefix_len > ADDR_BITS) ? ADDR_BITS : int'(r.prefix_len);
			for (d = 0; d < span && !full; d++) begin
				br  = r.dest_addr[ADDR_BITS-1-d];
				nxt = trie_child[cur][br];
				if (nxt == 0) begin
					if (nodes_alloc >= NODE_COUNT) begin
						full = 1'b1;
					end else begin
						nxt = nodes_alloc;
						nodes_alloc++;
						trie_route[nxt]    = 1'b0;
						trie_hop[nxt]      = 32'd0;
						trie_child[nxt][0] = 0;
						trie_child[nxt][1] = 0;
						trie_child[cur][br] = nxt;
					end
				end
				if (!full)
					cur = nxt;
			end
			if (full) begin
				res.status = ST_FULL;
			end else begin
				trie_route[cur] = 1'b1;
				trie_hop[cur]   = r.next_hop;
			end
		end else if (r.dest_addr == BCAST_ADDR || r.dest_addr == router_addr) begin
			res.status = ST_LOCAL;
		end else begin
			for (d = 0; d <= ADDR_BITS; d++) begin
				if (trie_route[cur]) begin
					found   = 1'b1;
					hit_hop = trie_hop[cur];
				end
				if (d == ADDR_BITS)
					break;
				nxt = trie_child[cur][r.dest_addr[ADDR_BITS-1-d]];
				if (nxt == 0)
					break;
				cur = nxt;
			end
			// missing route wins over an expired TTL
			if (!found) begin
				res.status = ST_NOROUTE;
			end else if (r.ttl == 8'd0) begin
				res.status = ST_TTL;
			end else begin
				res.status       = ST_FWD;
				res.out_next_hop = hit_hop;
				res.new_ttl      = r.ttl - 8'd1;
			end
		end
		return res;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones, plus calm runs
	function automatic int pick_idle(inout int calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic route_req_t mk_req(logic op, logic [31:0] dest, logic [5:0] plen,
			logic [31:0] hop, logic [7:0] ttl);
		return '{op, dest, plen, hop, ttl};
	endfunction

	// adds cluster around a few bases so lookups share paths; ttl is noise
	function automatic route_req_t gen_add_item();
		route_req_t it;
		int         roll, k;
		roll = $urandom_range(0, 99);
		k    = $urandom_range(0, $urandom_range(0, 31));
		it.operation = OP_ADD;
		it.dest_addr = ($urandom_range(0, 9) == 0) ? $urandom :
			route_bases[$urandom_range(0, 7)] ^ ($urandom & (32'hFFFF_FFFF >> (32 - k)));
		if (roll < 15)
			it.prefix_len = 6'($urandom_range(0, 8));
		else if (roll < 60)
			it.prefix_len = 6'($urandom_range(9, 24));
		else if (roll < 90)
			it.prefix_len = 6'($urandom_range(25, 32));
		else
			it.prefix_len = 6'($urandom_range(33, 63));
		it.next_hop = $urandom;
		it.ttl      = 8'($urandom);
		added_dests.push_back(it.dest_addr);
		return it;
	endfunction

	// forwards mostly land near a known route; prefix_len and next_hop are noise
	function automatic route_req_t gen_fwd_item();
		route_req_t it;
		int         roll, k;
		roll = $urandom_range(0, 99);
		k    = $urandom_range(0, 32);
		it.operation = OP_FWD;
		if (roll < 60 && added_dests.size() != 0)
			it.dest_addr = added_dests[$urandom_range(0, added_dests.size() - 1)] ^
				($urandom & (32'hFFFF_FFFF >> (32 - k)));
		else if (roll < 68)
			it.dest_addr = router_addr;
		else if (roll < 73)
			it.dest_addr = BCAST_ADDR;
		else
			it.dest_addr = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			it.ttl = 8'd0;
		else if (roll < 20)
			it.ttl = 8'd1;
		else if (roll < 25)
			it.ttl = 8'hFF;
		else
			it.ttl = 8'($urandom);
		it.prefix_len = 6'($urandom_range(0, 63));
		it.next_hop   = $urandom;
		return it;
	endfunction

	task automatic queue_req(input route_req_t it);
		route_requests.push_back(it);
		reqs_queued++;
	endtask

	task automatic queue_mix(input int count, input int add_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < add_pct)
				queue_req(gen_add_item());
			else
				queue_req(gen_fwd_item());
		end
	endtask

	// block is idle once every request is in and every response is out
	task automatic wait_idle();
		while (reqs_accepted != reqs_queued || expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write then read back; shadow updated while the block is idle
	task automatic set_local_addr(input logic [31:0] value);
		logic [31:0] readback;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LOCAL_ADDR_OFS;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		router_addr = value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== value) begin
			$error("local_addr readback: expected %08h, got %08h", value, readback);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: next transfer goes out once the last one was taken
	// ------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= OP_ADD;
			req_ch.dest_addr  <= '0;
			req_ch.prefix_len <= '0;
			req_ch.next_hop   <= '0;
			req_ch.ttl        <= '0;
			send_gap  = 0;
			send_calm = 0;
		end else if (!req_ch.valid || req_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (route_requests.size() != 0) begin
				head_req = route_requests.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.operation  <= head_req.operation;
				req_ch.dest_addr  <= head_req.dest_addr;
				req_ch.prefix_len <= head_req.prefix_len;
				req_ch.next_hop   <= head_req.next_hop;
				req_ch.ttl        <= head_req.ttl;
				send_gap = pick_idle(send_calm);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response sink: random backpressure, independent of rsp.valid
	// ------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt  = 0;
			hold_calm = 0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			hold_cnt = pick_idle(hold_calm);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each request transfer, check each response
	// transfer against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		verdict_t want;
		if (!arst_n) begin
			req_taken    <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				expected_verdicts.push_back(forward_decision(mk_req(req_ch.operation,
					req_ch.dest_addr, req_ch.prefix_len, req_ch.next_hop, req_ch.ttl)));
				reqs_accepted++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("response transfer with no request outstanding");
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.out_next_hop !== want.out_next_hop) begin
						$error("out_next_hop: expected %08h, got %08h",
							want.out_next_hop, rsp_ch.out_next_hop);
						mismatches++;
					end
					if (rsp_ch.new_ttl !== want.new_ttl) begin
						$error("new_ttl: expected %0d, got %0d", want.new_ttl, rsp_ch.new_ttl);
						mismatches++;
					end
				end
			end
			// any transfer on any port keeps the watchdog quiet
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog: a hung handshake ends the run
	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		foreach (route_bases[i])
			route_bases[i] = $urandom;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: local_addr 0, empty table, then nested prefixes
		set_local_addr(32'h0000_0000);
		queue_req(mk_req(OP_FWD, 32'h0A01_0203, 6'd0, 32'd0, 8'd5));      // no route yet
		queue_req(mk_req(OP_FWD, BCAST_ADDR, 6'd63, $urandom, 8'd0));      // broadcast, ttl 0
		queue_req(mk_req(OP_FWD, 32'h0000_0000, 6'd0, 32'd0, 8'd9));       // own address
		queue_req(mk_req(OP_ADD, 32'hDEAD_BEEF, 6'd0, 32'h0101_0101, 8'hFF)); // default
		queue_req(mk_req(OP_FWD, 32'h5555_AAAA, 6'd17, 32'd0, 8'hFF));     // via default
		queue_req(mk_req(OP_FWD, 32'h5555_AAAA, 6'd0, 32'd0, 8'd0));       // ttl expired
		queue_req(mk_req(OP_ADD, 32'h0AFF_FFFF, 6'd8, 32'h0A0A_0A0A, 8'd0)); // host bits set
		queue_req(mk_req(OP_FWD, 32'h0A01_0203, 6'd0, 32'd0, 8'd1));       // ttl 1 -> 0
		queue_req(mk_req(OP_ADD, 32'h0A01_0000, 6'd16, 32'h0B0B_0B0B, 8'd0));
		queue_req(mk_req(OP_FWD, 32'h0A01_0203, 6'd0, 32'd0, 8'd64));      // /16 wins
		queue_req(mk_req(OP_FWD, 32'h0A02_0000, 6'd0, 32'd0, 8'd64));      // back to /8
		queue_req(mk_req(OP_ADD, 32'h0A01_0203, 6'd32, 32'h0C0C_0C0C, 8'd0)); // host route
		queue_req(mk_req(OP_FWD, 32'h0A01_0203, 6'd0, 32'd0, 8'd2));
		queue_req(mk_req(OP_FWD, 32'h0A01_0202, 6'd0, 32'd0, 8'd2));       // sibling -> /16
		queue_req(mk_req(OP_ADD, 32'hC0A8_0101, 6'd63, 32'h0E0E_0E0E, 8'd0)); // saturates
		queue_req(mk_req(OP_FWD, 32'hC0A8_0101, 6'd0, 32'd0, 8'd3));
		queue_req(mk_req(OP_ADD, 32'h0A00_0000, 6'd8, 32'h0F0F_0F0F, 8'd0)); // duplicate
		queue_req(mk_req(OP_FWD, 32'h0A02_0000, 6'd0, 32'd0, 8'd7));
		queue_req(mk_req(OP_ADD, 32'h8000_0000, 6'd1, 32'hFFFF_FFFF, 8'd0));
		queue_req(mk_req(OP_FWD, 32'hFFFF_FFFE, 6'd33, 32'd0, 8'd2));
		queue_req(mk_req(OP_ADD, 32'hFFFF_FFFF, 6'd32, 32'h1234_5678, 8'd0));
		queue_req(mk_req(OP_FWD, BCAST_ADDR, 6'd0, 32'd0, 8'd40));         // local beats route
		queue_req(mk_req(OP_ADD, 32'h0000_0000, 6'd32, 32'h8765_4321, 8'd0));
		queue_req(mk_req(OP_FWD, 32'h0000_0000, 6'd0, 32'd0, 8'd40));      // local beats route
		queue_req(mk_req(OP_FWD, 32'h0000_0001, 6'd0, 32'd0, 8'd0));       // default, ttl 0
		wait_idle();

		// local address equal to broadcast
		set_local_addr(32'hFFFF_FFFF);
		queue_mix(620, 30);
		wait_idle();

		// local address inside a routed prefix
		set_local_addr(added_dests[$urandom_range(0, added_dests.size() - 1)]);
		queue_mix(620, 30);
		wait_idle();

		// exhaust the node pool with host routes, then keep mixing on a full table
		set_local_addr($urandom);
		repeat (48)
			queue_req(mk_req(OP_ADD, $urandom, 6'd32, $urandom, 8'($urandom)));
		queue_mix(590, 30);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
